@@ hw/rtl/pstd_pkg.sv @@
package pstd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned BIT_IDX_W = 3;

  // header byte layout
  localparam int unsigned KIND_POS = 7;

  // echo status codes
  localparam logic [BYTE_W-1:0] ECHO_HEADER  = 8'h00;
  localparam logic [BYTE_W-1:0] ECHO_PAYLOAD = 8'hCC;

  // index of the final serial bit of a byte
  localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;

  // level of the data/command line while no byte is being shifted
  localparam logic DC_IDLE = 1'b1;

  // classified request passed from front to back
  typedef struct packed {
    logic              is_payload;
    logic              dc;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

@@ hw/rtl/packet_to_spi_command_deframer.sv @@
// Packet to serial command deframer. Bytes of a host packet are pushed in one
// per cycle; a byte arriving with no payload pending is a header (top bit:
// 1 data, 0 command; low seven bits: payload byte count). A header gives one
// result with bit_valid low, dc_level high and echo 0x00. Each payload byte
// gives eight results, MSB first, with bit_valid high, dc_level from the kind
// bit and echo 0xCC; last_of_item marks the final result of every byte.
// A byte marked last_in_packet clears the count and kind once handled.
// The front classifies bytes at the input and takes one per cycle while the
// request queue (QUEUE_DEPTH entries) has room. The back serializer issues one
// result per cycle while the output register is empty or popped, and loads the
// next request as the current one issues its last result. A byte passes through
// the queue, the current-request register and the result register in that order.
module packet_to_spi_command_deframer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [pstd_pkg::BYTE_W-1:0] in_packet_byte,
  input  logic                        in_last_in_packet,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_bit_valid,
  output logic                        out_serial_bit,
  output logic                        out_dc_level,
  output logic [pstd_pkg::BYTE_W-1:0] out_echo_byte,
  output logic                        out_last_of_item
);

  pstd_pkg::cmd_t front_cmd;
  pstd_pkg::cmd_t queue_cmd;
  logic           queue_empty;
  logic           queue_pop;
  logic           accept;

  assign accept = in_push && !in_full;

  // byte classification and header tracking
  pstd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .packet_byte    (in_packet_byte),
    .last_in_packet (in_last_in_packet),
    .cmd            (front_cmd)
  );

  // request queue between front and back
  pstd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (queue_pop),
    .pop_data  (queue_cmd),
    .empty     (queue_empty)
  );

  // serializer and result register
  pstd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (queue_cmd),
    .cmd_empty        (queue_empty),
    .cmd_pop          (queue_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_bit_valid    (out_bit_valid),
    .out_serial_bit   (out_serial_bit),
    .out_dc_level     (out_dc_level),
    .out_echo_byte    (out_echo_byte),
    .out_last_of_item (out_last_of_item)
  );

endmodule

@@ hw/rtl/pstd_front.sv @@
module pstd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [pstd_pkg::BYTE_W-1:0]   packet_byte,
  input  logic                          last_in_packet,
  output pstd_pkg::cmd_t                cmd
);

  logic [pstd_pkg::COUNT_W-1:0] remaining_r, remaining_nxt;
  logic                         kind_r, kind_nxt;
  logic                         is_header;

  // a byte is a header whenever no payload is pending
  assign is_header = (remaining_r == '0);

  // classify the incoming byte
  always_comb begin
    cmd.is_payload = !is_header;
    cmd.dc         = is_header ? pstd_pkg::DC_IDLE : kind_r;
    cmd.data       = packet_byte;
  end

  // header tracking, cleared after the final byte of a packet
  always_comb begin
    remaining_nxt = remaining_r;
    kind_nxt      = kind_r;
    if (accept) begin
      if (is_header) begin
        remaining_nxt = packet_byte[pstd_pkg::COUNT_W-1:0];
        kind_nxt      = packet_byte[pstd_pkg::KIND_POS];
      end else begin
        remaining_nxt = remaining_r - pstd_pkg::COUNT_W'(1);
      end
      if (last_in_packet) begin
        remaining_nxt = '0;
        kind_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remaining_r <= '0;
      kind_r      <= 1'b0;
    end else begin
      remaining_r <= remaining_nxt;
      kind_r      <= kind_nxt;
    end
  end

endmodule

@@ hw/rtl/pstd_queue.sv @@
module pstd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pstd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output pstd_pkg::cmd_t pop_data,
  output logic           empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pstd_pkg::cmd_t   entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  // fill count stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue fill count beyond depth");

  // pointers agree with the fill count
  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FULL_CNT) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");

  // full and empty never flagged together
  a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("queue both full and empty");

endmodule

@@ hw/rtl/pstd_back.sv @@
module pstd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pstd_pkg::cmd_t              cmd,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_bit_valid,
  output logic                        out_serial_bit,
  output logic                        out_dc_level,
  output logic [pstd_pkg::BYTE_W-1:0] out_echo_byte,
  output logic                        out_last_of_item
);

  // request being carried out
  logic                           cur_valid_r, cur_valid_nxt;
  logic                           cur_payload_r, cur_payload_nxt;
  logic                           cur_dc_r, cur_dc_nxt;
  logic [pstd_pkg::BYTE_W-1:0]    shift_r, shift_nxt;
  logic [pstd_pkg::BIT_IDX_W-1:0] idx_r, idx_nxt;

  // output register
  logic                        res_valid_r, res_valid_nxt;
  logic                        res_bit_valid_r, res_bit_valid_nxt;
  logic                        res_serial_r, res_serial_nxt;
  logic                        res_dc_r, res_dc_nxt;
  logic [pstd_pkg::BYTE_W-1:0] res_echo_r, res_echo_nxt;
  logic                        res_last_r, res_last_nxt;

  logic advance, cur_done, load_cur;

  assign advance  = !res_valid_r || out_pop;
  assign cur_done = cur_valid_r && (!cur_payload_r || idx_r == pstd_pkg::LAST_BIT_IDX);
  assign load_cur = !cmd_empty && (!cur_valid_r || (advance && cur_done));
  assign cmd_pop  = load_cur;

  // serializer and output register
  always_comb begin
    cur_valid_nxt     = cur_valid_r;
    cur_payload_nxt   = cur_payload_r;
    cur_dc_nxt        = cur_dc_r;
    shift_nxt         = shift_r;
    idx_nxt           = idx_r;
    res_valid_nxt     = res_valid_r;
    res_bit_valid_nxt = res_bit_valid_r;
    res_serial_nxt    = res_serial_r;
    res_dc_nxt        = res_dc_r;
    res_echo_nxt      = res_echo_r;
    res_last_nxt      = res_last_r;

    if (advance) begin
      res_valid_nxt     = cur_valid_r;
      res_bit_valid_nxt = cur_payload_r;
      res_serial_nxt    = cur_payload_r && shift_r[pstd_pkg::BYTE_W-1];
      res_dc_nxt        = cur_dc_r;
      res_echo_nxt      = cur_payload_r ? pstd_pkg::ECHO_PAYLOAD : pstd_pkg::ECHO_HEADER;
      res_last_nxt      = cur_done;
      if (cur_valid_r) begin
        shift_nxt = {shift_r[pstd_pkg::BYTE_W-2:0], 1'b0};
        idx_nxt   = idx_r + pstd_pkg::BIT_IDX_W'(1);
      end
      if (cur_done) begin
        cur_valid_nxt = 1'b0;
      end
    end

    if (load_cur) begin
      cur_valid_nxt   = 1'b1;
      cur_payload_nxt = cmd.is_payload;
      cur_dc_nxt      = cmd.dc;
      shift_nxt       = cmd.data;
      idx_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_payload_r   <= cur_payload_nxt;
    cur_dc_r        <= cur_dc_nxt;
    shift_r         <= shift_nxt;
    idx_r           <= idx_nxt;
    res_bit_valid_r <= res_bit_valid_nxt;
    res_serial_r    <= res_serial_nxt;
    res_dc_r        <= res_dc_nxt;
    res_echo_r      <= res_echo_nxt;
    res_last_r      <= res_last_nxt;
  end

  assign out_empty        = !res_valid_r;
  assign out_bit_valid    = res_bit_valid_r;
  assign out_serial_bit   = res_serial_r;
  assign out_dc_level     = res_dc_r;
  assign out_echo_byte    = res_echo_r;
  assign out_last_of_item = res_last_r;

  // a header result is a single idle-line status
  a_header_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_bit_valid_r) |->
      (res_dc_r == pstd_pkg::DC_IDLE && res_echo_r == pstd_pkg::ECHO_HEADER && res_last_r))
    else $error("malformed header result");

  // a payload byte is never abandoned part way through
  a_no_partial_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && cur_payload_r && idx_r != pstd_pkg::LAST_BIT_IDX)
      |=> (cur_valid_r && cur_payload_r))
    else $error("payload byte dropped before its last bit");

  // a new request is only taken once the current one has been fully issued
  a_load_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (load_cur && cur_valid_r) |-> (advance && cur_done))
    else $error("request replaced before completion");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // one serial result as seen on the output queue
  typedef struct packed {
    logic                        bit_valid;
    logic                        serial_bit;
    logic                        dc_level;
    logic [pstd_pkg::BYTE_W-1:0] echo;
    logic                        last_of_item;
  } spi_result_t;

  // directed row: byte, end-of-packet flag, and an optional hand-written result
  typedef struct packed {
    logic [pstd_pkg::BYTE_W-1:0] pkt_byte;
    logic                        pkt_last;
    logic                        has_exp;
    spi_result_t                 exp_result;
  } stim_row_t;

  localparam spi_result_t HDR =
    '{1'b0, 1'b0, pstd_pkg::DC_IDLE, pstd_pkg::ECHO_HEADER, 1'b1};
  localparam spi_result_t NONE = '0;
  localparam int NUM_ROWS = 19;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [pstd_pkg::BYTE_W-1:0] in_packet_byte = '0;
  logic in_last_in_packet = 1'b0;
  logic in_has_exp = 1'b0;
  spi_result_t in_exp_result = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic out_bit_valid;
  logic out_serial_bit;
  logic out_dc_level;
  logic [pstd_pkg::BYTE_W-1:0] out_echo_byte;
  logic out_last_of_item;

  // deframer state mirrored by the predictor
  logic [pstd_pkg::COUNT_W-1:0] pending_count = '0;
  logic pending_kind = 1'b0;
  spi_result_t pending_results_q[$];

  int send_idle_pct = 17;
  int recv_idle_pct = 78;
  bit long_hold_armed = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;

  int mismatch_count = 0;
  int bytes_offered = 0;
  int headers_seen = 0;
  int payload_seen = 0;
  int results_checked = 0;
  int full_cycles = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, HDR},   // command header, nothing follows
    '{8'h80, 1'b1, 1'b1, HDR},   // data header, empty packet
    '{8'h02, 1'b0, 1'b1, HDR},   // command, two bytes
    '{8'hFF, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b1, 1'b0, NONE},
    '{8'h81, 1'b0, 1'b1, HDR},   // data, one byte
    '{8'hA5, 1'b1, 1'b0, NONE},
    '{8'hFF, 1'b1, 1'b1, HDR},   // full count, packet ends on the header
    '{8'h7F, 1'b0, 1'b1, HDR},   // command, full count
    '{8'h5A, 1'b0, 1'b0, NONE},
    '{8'h3C, 1'b1, 1'b0, NONE},  // cut short, rest dropped
    '{8'h83, 1'b0, 1'b1, HDR},
    '{8'h01, 1'b0, 1'b0, NONE},
    '{8'h80, 1'b0, 1'b0, NONE},
    '{8'hFE, 1'b0, 1'b0, NONE},  // count runs out without end flag
    '{8'h01, 1'b0, 1'b1, HDR},
    '{8'h55, 1'b0, 1'b0, NONE},
    '{8'h00, 1'b0, 1'b1, HDR},
    '{8'hC0, 1'b1, 1'b1, HDR}
  };

  packet_to_spi_command_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_packet_byte    (in_packet_byte),
    .in_last_in_packet (in_last_in_packet),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_bit_valid     (out_bit_valid),
    .out_serial_bit    (out_serial_bit),
    .out_dc_level      (out_dc_level),
    .out_echo_byte     (out_echo_byte),
    .out_last_of_item  (out_last_of_item)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // predictor: header sets count and kind, payload shifts out msb first
  function automatic void deframe_byte(input logic [pstd_pkg::BYTE_W-1:0] b, input logic l,
                                       input bit emit);
    spi_result_t r;
    if (pending_count == '0) begin
      pending_count = b[pstd_pkg::COUNT_W-1:0];
      pending_kind = b[pstd_pkg::KIND_POS];
      r = '{1'b0, 1'b0, pstd_pkg::DC_IDLE, pstd_pkg::ECHO_HEADER, 1'b1};
      if (emit) pending_results_q.push_back(r);
      headers_seen++;
    end else begin
      for (int i = pstd_pkg::BYTE_W - 1; i >= 0; i--) begin
        r = '{1'b1, b[i], pending_kind, pstd_pkg::ECHO_PAYLOAD, i == 0};
        pending_results_q.push_back(r);
      end
      pending_count = pending_count - pstd_pkg::COUNT_W'(1);
      payload_seen++;
    end
    if (l) begin
      pending_count = '0;
      pending_kind = 1'b0;
    end
  endfunction

  function automatic void note_failure(input string what, input spi_result_t want,
                                       input spi_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t %s: exp v=%b b=%b dc=%b e=%h l=%b, got v=%b b=%b dc=%b e=%h l=%b",
               $realtime, what, want.bit_valid, want.serial_bit, want.dc_level, want.echo,
               want.last_of_item, got.bit_valid, got.serial_bit, got.dc_level, got.echo,
               got.last_of_item);
  endfunction

  // input monitor: every accepted request feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_push) begin
      if (in_full) begin
        full_cycles++;
      end else if (in_has_exp) begin
        pending_results_q.push_back(in_exp_result);
        deframe_byte(in_packet_byte, in_last_in_packet, 1'b0);
      end else begin
        deframe_byte(in_packet_byte, in_last_in_packet, 1'b1);
      end
    end
  end

  // output checker
  always @(posedge clk) begin
    spi_result_t got;
    spi_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_bit_valid, out_serial_bit, out_dc_level, out_echo_byte, out_last_of_item};
      results_checked++;
      if (pending_results_q.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = pending_results_q.pop_front();
        if (got.bit_valid !== want.bit_valid || got.serial_bit !== want.serial_bit ||
            got.dc_level !== want.dc_level || got.echo !== want.echo ||
            got.last_of_item !== want.last_of_item)
          note_failure("result mismatch", want, got);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to fill the block
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else if (long_hold_armed && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one request and wait until it is taken
  task automatic offer_byte(input logic [pstd_pkg::BYTE_W-1:0] b, input logic l,
                            input logic has_exp, input spi_result_t exp_result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_packet_byte <= b;
    in_last_in_packet <= l;
    in_has_exp <= has_exp;
    in_exp_result <= exp_result;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_offered++;
  endtask

  // mostly well-formed packets, some cut short or missing the end flag
  task automatic send_random_packet(input int max_count);
    int count;
    int cut;
    bit no_end;
    logic kind;
    kind = 1'($urandom_range(1));
    count = ($urandom_range(99) < 80) ? $urandom_range(max_count) : $urandom_range(127);
    cut = count;
    if (count > 6) cut = $urandom_range(4);
    else if ($urandom_range(99) < 10) cut = $urandom_range(count);
    no_end = ($urandom_range(99) < 10);
    offer_byte({kind, count[pstd_pkg::COUNT_W-1:0]}, (cut == 0) && !no_end, 1'b0, NONE);
    for (int i = 0; i < cut; i++)
      offer_byte(pstd_pkg::BYTE_W'($urandom_range(255)), (i == cut - 1) && !no_end,
                 1'b0, NONE);
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_ROWS; i++)
      offer_byte(directed_rows[i].pkt_byte, directed_rows[i].pkt_last,
                 directed_rows[i].has_exp, directed_rows[i].exp_result);

    // long receiver hold-off while the sender keeps pushing
    send_idle_pct = 0;
    long_hold_armed = 1'b1;
    offer_byte({1'b1, 7'd12}, 1'b0, 1'b0, NONE);
    for (int i = 0; i < 12; i++)
      offer_byte(pstd_pkg::BYTE_W'($urandom_range(255)), i == 11, 1'b0, NONE);

    // random traffic under three idling patterns
    send_idle_pct = 17;
    recv_idle_pct = 78;
    while (bytes_offered < 65) send_random_packet(4);
    send_idle_pct = 78;
    recv_idle_pct = 17;
    while (bytes_offered < 95) send_random_packet(4);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_offered < 130) send_random_packet(6);
    in_push <= 1'b0;

    // drain
    @(posedge clk);
    while (pending_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results_q.size() != 0) note_failure("result never arrived", '0, '0);

    $display("summary: %0d bytes (%0d headers, %0d payload), %0d results checked",
             bytes_offered, headers_seen, payload_seen, results_checked);
    $display("summary: %0d cycles with input held off by full, %0d failures",
             full_cycles, mismatch_count);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
